### rtl/tsph_pkg.sv
`default_nettype none
package tsph_pkg;
   localparam int unsigned CODE_W  = 4;
   localparam int unsigned VALUE_W = 42;

   typedef enum logic [CODE_W-1:0] {
      FC_HEADER   = 4'd0,
      FC_AF       = 4'd1,
      FC_PCR      = 4'd2,
      FC_OPCR     = 4'd3,
      FC_SPLICE   = 4'd4,
      FC_PRIVLEN  = 4'd5,
      FC_PRIVBYTE = 4'd6,
      FC_EXT      = 4'd7,
      FC_LTW      = 4'd8,
      FC_RATE     = 4'd9,
      FC_STYPE    = 4'd10,
      FC_END      = 4'd11
   } field_code_type;

   typedef enum logic [3:0] {
      PH_HEADER   = 4'd0,
      PH_AFLEN    = 4'd1,
      PH_AFFLAGS  = 4'd2,
      PH_PCR      = 4'd3,
      PH_OPCR     = 4'd4,
      PH_SPLICE   = 4'd5,
      PH_PRIVLEN  = 4'd6,
      PH_PRIVDATA = 4'd7,
      PH_EXTLEN   = 4'd8,
      PH_EXTFLAGS = 4'd9,
      PH_LTW      = 4'd10,
      PH_RATE     = 4'd11,
      PH_SEAMLESS = 4'd12,
      PH_STUFF    = 4'd13,
      PH_PAYLOAD  = 4'd14
   } phase_type;

   localparam logic [7:0] SYNC_BYTE = 8'h47;

   // One or two results produced by one byte.
   typedef struct packed {
      logic [1:0]         count;
      field_code_type     code0;
      logic [VALUE_W-1:0] value0;
      logic               last0;
      field_code_type     code1;
      logic [VALUE_W-1:0] value1;
      logic               last1;
   } result_pair_type;
endpackage
`default_nettype wire

### rtl/tsph_front.sv
`default_nettype none
module tsph_front #(
   parameter int unsigned PACKET_BYTES = 188
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     valid,
   input  wire logic [7:0]               data_byte,
   input  wire logic                     start_of_packet,
   output tsph_pkg::result_pair_type     pair
);
   import tsph_pkg::*;

   localparam logic [8:0] LAST_POS = 9'(PACKET_BYTES - 1);

   logic [7:0]  pos_ff, pos_in;
   logic        inpkt_ff, inpkt_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  afend_ff, afend_in;
   logic [7:0]  pend_ff, pend_in;
   logic [2:0]  extf_ff, extf_in;
   logic [47:0] acc_ff, acc_in;
   logic [1:0]  err_ff, err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         inpkt_ff <= 1'b0;
         phase_ff <= PH_HEADER;
         left_ff  <= '0;
         afend_ff <= '0;
         pend_ff  <= '0;
         extf_ff  <= '0;
         acc_ff   <= '0;
         err_ff   <= '0;
      end else if (valid) begin
         pos_ff   <= pos_in;
         inpkt_ff <= inpkt_in;
         phase_ff <= phase_in;
         left_ff  <= left_in;
         afend_ff <= afend_in;
         pend_ff  <= pend_in;
         extf_ff  <= extf_in;
         acc_ff   <= acc_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [7:0]  p;
      logic        done;
      logic        adv;
      logic [8:0]  e;
      logic [47:0] a;
      b = data_byte;
      pos_in = pos_ff; inpkt_in = inpkt_ff; phase_in = phase_ff; left_in = left_ff;
      afend_in = afend_ff; pend_in = pend_ff; extf_in = extf_ff;
      acc_in = acc_ff; err_in = err_ff;
      pair = '0;
      pair.code0 = FC_HEADER;
      pair.code1 = FC_HEADER;
      done = 1'b0; adv = 1'b0; e = '0; a = '0;
      if (start_of_packet) begin
         if (inpkt_ff) begin
            pair.count  = 2'd1;
            pair.code0  = FC_END;
            pair.value0 = VALUE_W'(err_ff | 2'b10);
            pair.last0  = 1'b1;
         end
         pos_in = '0; inpkt_in = 1'b1; phase_in = PH_HEADER; left_in = 8'd4;
         afend_in = '0; pend_in = '0; extf_in = '0; acc_in = '0; err_in = '0;
      end
      p = pos_in;
      if (inpkt_in) begin
         if (phase_in inside {[PH_PCR:PH_STUFF]} && p > afend_in) begin
            err_in[1] = 1'b1; pend_in = '0; extf_in = '0;
            phase_in = PH_PAYLOAD; left_in = '0; acc_in = '0;
         end
         a = {acc_in[39:0], b};
         case (phase_in)
            PH_HEADER, PH_PCR, PH_OPCR, PH_PRIVDATA, PH_LTW, PH_RATE,
            PH_SEAMLESS: begin
               acc_in = a;
               if (left_in != 8'd0) left_in = left_in - 8'd1;
               done = (left_in == 8'd0);
            end
            default: ;
         endcase
         // a field result never meets an early end, so it always takes slot 0
         case (phase_in)
            PH_HEADER: begin
               if (p == 8'd0 && b != SYNC_BYTE) err_in[0] = 1'b1;
               if (done) begin
                  pair.count = pair.count + 2'd1;
                  pair.code0 = FC_HEADER;
                  pair.value0 = VALUE_W'(a[31:0]);
                  if (b[5]) begin
                     phase_in = PH_AFLEN; left_in = 8'd1; acc_in = '0;
                  end else begin
                     phase_in = PH_PAYLOAD; left_in = '0; acc_in = '0;
                  end
               end
            end
            PH_AFLEN: begin
               e = 9'd4 + 9'(b);
               if (e > LAST_POS) begin
                  err_in[1] = 1'b1; e = LAST_POS;
               end
               afend_in = e[7:0];
               if (b == 8'd0) begin
                  pair.count = pair.count + 2'd1;
                  pair.code0 = FC_AF; pair.value0 = '0;
                  phase_in = PH_PAYLOAD; left_in = '0; acc_in = '0;
               end else begin
                  phase_in = PH_AFFLAGS; left_in = 8'd1; acc_in = 48'(b);
               end
            end
            PH_AFFLAGS: begin
               pend_in = b; extf_in = '0;
               pair.count = pair.count + 2'd1;
               pair.code0 = FC_AF; pair.value0 = VALUE_W'({acc_in[7:0], b});
               adv = 1'b1;
            end
            PH_PCR, PH_OPCR: if (done) begin
               pair.count = pair.count + 2'd1;
               pair.code0 = (phase_in == PH_PCR) ? FC_PCR : FC_OPCR;
               pair.value0 = VALUE_W'({a[47:15], a[8:0]});
               adv = 1'b1;
            end
            PH_SPLICE: begin
               pair.count = pair.count + 2'd1;
               pair.code0 = FC_SPLICE; pair.value0 = VALUE_W'(b);
               adv = 1'b1;
            end
            PH_PRIVLEN: begin
               pair.count = pair.count + 2'd1;
               pair.code0 = FC_PRIVLEN; pair.value0 = VALUE_W'(b);
               if (b != 8'd0) begin
                  phase_in = PH_PRIVDATA; left_in = b; acc_in = '0;
               end else adv = 1'b1;
            end
            PH_PRIVDATA: begin
               pair.count = pair.count + 2'd1;
               pair.code0 = FC_PRIVBYTE; pair.value0 = VALUE_W'(b);
               adv = done;
            end
            PH_EXTLEN: begin
               if (b == 8'd0) begin
                  pair.count = pair.count + 2'd1;
                  pair.code0 = FC_EXT; pair.value0 = '0;
                  adv = 1'b1;
               end else begin
                  phase_in = PH_EXTFLAGS; left_in = 8'd1; acc_in = 48'(b);
               end
            end
            PH_EXTFLAGS: begin
               extf_in = b[7:5];
               pair.count = pair.count + 2'd1;
               pair.code0 = FC_EXT; pair.value0 = VALUE_W'({acc_in[7:0], b});
               adv = 1'b1;
            end
            PH_LTW: if (done) begin
               pair.count = pair.count + 2'd1;
               pair.code0 = FC_LTW; pair.value0 = VALUE_W'(a[15:0]);
               adv = 1'b1;
            end
            PH_RATE: if (done) begin
               pair.count = pair.count + 2'd1;
               pair.code0 = FC_RATE; pair.value0 = VALUE_W'(a[21:0]);
               adv = 1'b1;
            end
            PH_SEAMLESS: if (done) begin
               pair.count = pair.count + 2'd1;
               pair.code0 = FC_STYPE; pair.value0 = VALUE_W'(a[39:36]);
               adv = 1'b1;
            end
            PH_STUFF: begin
               if (p >= afend_in) begin
                  phase_in = PH_PAYLOAD; left_in = '0; acc_in = '0;
               end
            end
            default: ;
         endcase
         if (adv) begin
            acc_in = '0;
            if (pend_in[4]) begin
               pend_in[4] = 1'b0; phase_in = PH_PCR; left_in = 8'd6;
            end else if (pend_in[3]) begin
               pend_in[3] = 1'b0; phase_in = PH_OPCR; left_in = 8'd6;
            end else if (pend_in[2]) begin
               pend_in[2] = 1'b0; phase_in = PH_SPLICE; left_in = 8'd1;
            end else if (pend_in[1]) begin
               pend_in[1] = 1'b0; phase_in = PH_PRIVLEN; left_in = 8'd1;
            end else if (pend_in[0]) begin
               pend_in[0] = 1'b0; phase_in = PH_EXTLEN; left_in = 8'd1;
            end else if (extf_in[2]) begin
               extf_in[2] = 1'b0; phase_in = PH_LTW; left_in = 8'd2;
            end else if (extf_in[1]) begin
               extf_in[1] = 1'b0; phase_in = PH_RATE; left_in = 8'd3;
            end else if (extf_in[0]) begin
               extf_in[0] = 1'b0; phase_in = PH_SEAMLESS; left_in = 8'd5;
            end else begin
               phase_in = (p >= afend_in) ? PH_PAYLOAD : PH_STUFF; left_in = '0;
            end
         end
         pos_in = p + 8'd1;
         // the end result takes the first free slot
         if (9'(p) + 9'd1 >= 9'(PACKET_BYTES)) begin
            if (pair.count == 2'd0) begin
               pair.code0 = FC_END; pair.value0 = VALUE_W'(err_in); pair.last0 = 1'b1;
            end else begin
               pair.code1 = FC_END; pair.value1 = VALUE_W'(err_in); pair.last1 = 1'b1;
            end
            pair.count = pair.count + 2'd1;
            inpkt_in = 1'b0;
         end
      end
      if (!valid) pair.count = '0;
   end
endmodule
`default_nettype wire

### rtl/tsph_back.sv
`default_nettype none
module tsph_back #(
   parameter int unsigned DEPTH_LOG2 = 2
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire tsph_pkg::result_pair_type       pair,
   output logic                                 full,
   output logic                                 empty,
   input  wire logic                            pop,
   output tsph_pkg::field_code_type             code,
   output logic [tsph_pkg::VALUE_W-1:0]         value,
   output logic                                 last
);
   import tsph_pkg::*;

   localparam int unsigned DEPTH = 1 << DEPTH_LOG2;
   typedef struct packed {
      field_code_type     code;
      logic [VALUE_W-1:0] value;
      logic               last;
   } entry_type;

   entry_type                mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [DEPTH_LOG2:0]      cnt_ff, cnt_in;
   logic                     do_pop;

   assign do_pop = pop && !empty;
   assign empty  = (cnt_ff == '0);
   // keep room for the two results one byte can cause
   assign full   = (cnt_ff > (DEPTH_LOG2+1)'(DEPTH - 2));
   assign code   = mem_ff[rd_ff].code;
   assign value  = mem_ff[rd_ff].value;
   assign last   = mem_ff[rd_ff].last;

   always_comb begin
      wr_in  = wr_ff + DEPTH_LOG2'(pair.count);
      rd_in  = rd_ff + DEPTH_LOG2'(do_pop);
      cnt_in = cnt_ff + (DEPTH_LOG2+1)'(pair.count) - (DEPTH_LOG2+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair.count != 2'd0)
         mem_ff[wr_ff] <= '{pair.code0, pair.value0, pair.last0};
      if (pair.count == 2'd2)
         mem_ff[wr_ff + DEPTH_LOG2'(1)] <= '{pair.code1, pair.value1, pair.last1};
   end
endmodule
`default_nettype wire

### rtl/ts_packet_header_parser_top.sv
`default_nettype none
// channel   | ports                                       | handshake
// request   | req_data_byte, req_start_of_packet          | req_push / req_full
// result    | rsp_field_code, rsp_field_value, rsp_last_of_packet | rsp_pop / rsp_empty
// One request per cycle unless req_full; its results are queued at the accepting edge.
// The parser state advances by one byte each accepted request, no stall inside.
// req_full rises when the result queue lacks room for two results.
// Synchronous reset empties the queue and returns the parser to header phase.
module ts_packet_header_parser_top #(
   parameter int unsigned PACKET_BYTES = 188,
   parameter int unsigned QUEUE_LOG2   = 3
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [7:0]                      req_data_byte,
   input  wire logic                            req_start_of_packet,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [tsph_pkg::CODE_W-1:0]          rsp_field_code,
   output logic [tsph_pkg::VALUE_W-1:0]         rsp_field_value,
   output logic                                 rsp_last_of_packet
);
   import tsph_pkg::*;

   result_pair_type pair;
   field_code_type  code;
   logic            take;

   assign take = req_push && !req_full;
   assign rsp_field_code = code;

   tsph_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
      .clock(clock), .reset(reset), .valid(take),
      .data_byte(req_data_byte), .start_of_packet(req_start_of_packet), .pair(pair)
   );

   tsph_back #(.DEPTH_LOG2(QUEUE_LOG2)) u_back (
      .clock(clock), .reset(reset), .pair(pair), .full(req_full), .empty(rsp_empty),
      .pop(rsp_pop), .code(code), .value(rsp_field_value), .last(rsp_last_of_packet)
   );

`ifndef SYNTHESIS
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      req_full |-> pair.count == 2'd0) else $error("write while full");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_of_packet |-> code == FC_END) else $error("last flag");
   a_pair_bound: assert property (@(posedge clock) disable iff (reset)
      pair.count != 2'd3) else $error("pair count");
`endif
endmodule
`default_nettype wire
